/* rtl/hctm_pkg.sv */
`default_nettype none

package hctm_pkg;

   localparam int Channels = 32;
   localparam int ChIdxW = (Channels > 1) ? $clog2(Channels) : 1;

   localparam int DivBits = 4;
   localparam int DivCycles = 32 / DivBits;
   localparam int DivCntW = (DivCycles > 1) ? $clog2(DivCycles) : 1;

   localparam logic [28:0] OneQ28 = 29'h1000_0000;
   localparam logic signed [24:0] OffsA = 25'sd1280;
   localparam logic [23:0] OffsB = 24'd76800;
   localparam logic [31:0] HGain = 32'd50000;

   localparam logic [31:0] RstFree = 32'd96300067;
   localparam logic [31:0] RstCleft = 32'd347719;
   localparam logic [31:0] RstReproc = 32'd34504468;

   localparam logic [31:0] RstGainDt = 32'd12173944;
   localparam logic [31:0] RstReplenishDt = 32'd30740;
   localparam logic [31:0] RstLossDt = 32'd15217430;
   localparam logic [31:0] RstReuptakeDt = 32'd40052276;
   localparam logic [31:0] RstReprocessDt = 32'd403628;
   localparam logic [31:0] RstSpontLevel = 32'd4244600;

   typedef enum logic [2:0] {
      CSR_GAIN_DT = 3'd0,
      CSR_REPLENISH_DT = 3'd1,
      CSR_LOSS_DT = 3'd2,
      CSR_REUPTAKE_DT = 3'd3,
      CSR_REPROCESS_DT = 3'd4,
      CSR_SUBTRACT_SPONT = 3'd5,
      CSR_SPONT_LEVEL = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [23:0] sample;
      logic [4:0] channel;
   } req_type;

   typedef struct packed {
      logic [31:0] rate;
      logic [4:0] out_channel;
   } rsp_type;

   typedef struct packed {
      logic [31:0] free_pool;
      logic [31:0] cleft_pool;
      logic [31:0] reprocess_pool;
   } pool_set_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NUMER,
      ST_DIVIDE,
      ST_EJECT,
      ST_UPDATE,
      ST_RATE,
      ST_OUTPUT
   } state_type;

endpackage

`default_nettype wire

/* rtl/hair_cell_transmitter_model_top.sv */
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_payload (sample, channel)
// rsp       out        rsp_valid / rsp_ready     rsp_payload (rate, out_channel)
// csr       in         csr_valid / csr_ready     csr_index, csr_wdata
//
// A transaction for a valid channel runs from acceptance through the permeability numerator,
// a 4-bit-per-cycle divider (the shared multiplier forms the four rate products meanwhile),
// then eject, update, rate and output states before the next acceptance; the output state
// waits while the output register holds a result not yet taken. Out of range goes to output.
// Reset clears one valid bit per channel; an unwritten channel reads as the steady state.
// A result waits in the output register while the next transaction is accepted.

module hair_cell_transmitter_model_top (
   input wire clock,
   input wire reset,
   input wire req_valid,
   output logic req_ready,
   input wire hctm_pkg::req_type req_payload,
   output logic rsp_valid,
   input wire rsp_ready,
   output hctm_pkg::rsp_type rsp_payload,
   input wire csr_valid,
   output logic csr_ready,
   input wire [2:0] csr_index,
   input wire [31:0] csr_wdata
);

   hctm_pkg::state_type state_ff, state_in;

   logic [31:0] gain_dt_ff, replenish_dt_ff, loss_dt_ff, reuptake_dt_ff, reprocess_dt_ff;
   logic [31:0] spont_level_ff;
   logic subtract_spont_ff;

   hctm_pkg::pool_set_type pool_mem [hctm_pkg::Channels];
   hctm_pkg::pool_set_type pool_rd_ff;
   hctm_pkg::pool_set_type pool_new;
   logic valid_rd_ff;
   logic [hctm_pkg::Channels-1:0] valid_ff;

   logic [hctm_pkg::ChIdxW-1:0] idx_ff;
   logic [4:0] chan_ff;
   logic skip_ff;
   logic in_range;
   logic signed [24:0] lim_sum;
   logic [23:0] lim_in, lim_ff;

   logic [23:0] den_ff, rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [hctm_pkg::DivCntW-1:0] div_cnt_ff;

   logic [31:0] pool_q, pool_c, pool_w;
   logic [31:0] room;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [35:0] rep_ff, lo_ff, ru_ff, rp_ff, ej_ff, full_ff;
   logic [31:0] cleft_ff;
   logic signed [39:0] free_sum, cleft_sum, reproc_sum;

   logic [35:0] diff;
   logic [31:0] rate_val;
   logic rsp_load;
   logic rsp_valid_ff;
   hctm_pkg::rsp_type rsp_ff;

   function automatic logic [31:0] clamp_pool(input logic signed [39:0] v);
      logic [31:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v[39:32] != 8'd0) begin
         r = '1;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign in_range = 32'(req_payload.channel) < hctm_pkg::Channels;
   assign lim_sum = 25'(req_payload.sample) + hctm_pkg::OffsA;
   assign lim_in = lim_sum[24] ? 24'd0 : lim_sum[23:0];

   assign pool_q = valid_rd_ff ? pool_rd_ff.free_pool : hctm_pkg::RstFree;
   assign pool_c = valid_rd_ff ? pool_rd_ff.cleft_pool : hctm_pkg::RstCleft;
   assign pool_w = valid_rd_ff ? pool_rd_ff.reprocess_pool : hctm_pkg::RstReproc;
   assign room = (pool_q < 32'(hctm_pkg::OneQ28)) ? (32'(hctm_pkg::OneQ28) - pool_q) : 32'd0;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         hctm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = in_range ? hctm_pkg::ST_NUMER : hctm_pkg::ST_OUTPUT;
            end
         end
         hctm_pkg::ST_NUMER: begin
            state_in = hctm_pkg::ST_DIVIDE;
         end
         hctm_pkg::ST_DIVIDE: begin
            if (div_cnt_ff == hctm_pkg::DivCntW'(hctm_pkg::DivCycles - 1)) begin
               state_in = hctm_pkg::ST_EJECT;
            end
         end
         hctm_pkg::ST_EJECT: begin
            state_in = hctm_pkg::ST_UPDATE;
         end
         hctm_pkg::ST_UPDATE: begin
            state_in = hctm_pkg::ST_RATE;
         end
         hctm_pkg::ST_RATE: begin
            state_in = hctm_pkg::ST_OUTPUT;
         end
         hctm_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = hctm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hctm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         hctm_pkg::ST_NUMER: begin
            mul_a = {8'd0, lim_ff};
            mul_b = gain_dt_ff;
         end
         hctm_pkg::ST_DIVIDE: begin
            case (div_cnt_ff)
               hctm_pkg::DivCntW'(0): begin
                  mul_a = replenish_dt_ff;
                  mul_b = room;
               end
               hctm_pkg::DivCntW'(1): begin
                  mul_a = loss_dt_ff;
                  mul_b = pool_c;
               end
               hctm_pkg::DivCntW'(2): begin
                  mul_a = reuptake_dt_ff;
                  mul_b = pool_c;
               end
               hctm_pkg::DivCntW'(3): begin
                  mul_a = reprocess_dt_ff;
                  mul_b = pool_w;
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         hctm_pkg::ST_EJECT: begin
            mul_a = quo_ff;
            mul_b = pool_q;
         end
         hctm_pkg::ST_RATE: begin
            mul_a = hctm_pkg::HGain;
            mul_b = cleft_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      logic [25:0] part;
      logic [25:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < hctm_pkg::DivBits; i++) begin
         part = {1'b0, rem_in, quo_in[31]};
         trial = part - {2'b00, den_ff};
         if (!trial[25]) begin
            rem_in = trial[23:0];
            quo_in = {quo_in[30:0], 1'b1};
         end else begin
            rem_in = part[23:0];
            quo_in = {quo_in[30:0], 1'b0};
         end
      end
   end

   always_comb begin
      free_sum = $signed({8'd0, pool_q}) + $signed({4'd0, rep_ff})
         - $signed({4'd0, ej_ff}) + $signed({4'd0, rp_ff});
      cleft_sum = $signed({8'd0, pool_c}) + $signed({4'd0, ej_ff})
         - $signed({4'd0, lo_ff}) - $signed({4'd0, ru_ff});
      reproc_sum = $signed({8'd0, pool_w}) + $signed({4'd0, ru_ff})
         - $signed({4'd0, rp_ff});
      pool_new.free_pool = clamp_pool(free_sum);
      pool_new.cleft_pool = clamp_pool(cleft_sum);
      pool_new.reprocess_pool = clamp_pool(reproc_sum);
   end

   always_comb begin
      diff = full_ff;
      rate_val = '0;
      if (subtract_spont_ff) begin
         diff = full_ff - {4'd0, spont_level_ff};
      end
      if (skip_ff) begin
         rate_val = '0;
      end else if (subtract_spont_ff && (full_ff < {4'd0, spont_level_ff})) begin
         rate_val = '0;
      end else if (diff[35:32] != 4'd0) begin
         rate_val = '1;
      end else begin
         rate_val = diff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hctm_pkg::ST_IDLE;
         div_cnt_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == hctm_pkg::ST_DIVIDE) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end else begin
            div_cnt_ff <= '0;
         end
         if (state_ff == hctm_pkg::ST_UPDATE) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_dt_ff <= hctm_pkg::RstGainDt;
         replenish_dt_ff <= hctm_pkg::RstReplenishDt;
         loss_dt_ff <= hctm_pkg::RstLossDt;
         reuptake_dt_ff <= hctm_pkg::RstReuptakeDt;
         reprocess_dt_ff <= hctm_pkg::RstReprocessDt;
         subtract_spont_ff <= 1'b0;
         spont_level_ff <= hctm_pkg::RstSpontLevel;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hctm_pkg::CSR_GAIN_DT: gain_dt_ff <= csr_wdata;
            hctm_pkg::CSR_REPLENISH_DT: replenish_dt_ff <= csr_wdata;
            hctm_pkg::CSR_LOSS_DT: loss_dt_ff <= csr_wdata;
            hctm_pkg::CSR_REUPTAKE_DT: reuptake_dt_ff <= csr_wdata;
            hctm_pkg::CSR_REPROCESS_DT: reprocess_dt_ff <= csr_wdata;
            hctm_pkg::CSR_SUBTRACT_SPONT: subtract_spont_ff <= csr_wdata[0];
            hctm_pkg::CSR_SPONT_LEVEL: spont_level_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pool_rd_ff <= pool_mem[hctm_pkg::ChIdxW'(req_payload.channel)];
      end
      if (state_ff == hctm_pkg::ST_UPDATE) begin
         pool_mem[idx_ff] <= pool_new;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         valid_rd_ff <= valid_ff[hctm_pkg::ChIdxW'(req_payload.channel)];
         idx_ff <= hctm_pkg::ChIdxW'(req_payload.channel);
         chan_ff <= req_payload.channel;
         skip_ff <= !in_range;
         lim_ff <= lim_in;
      end
      case (state_ff)
         hctm_pkg::ST_NUMER: begin
            den_ff <= lim_ff + hctm_pkg::OffsB;
            rem_ff <= mul_p[55:32];
            quo_ff <= mul_p[31:0];
         end
         hctm_pkg::ST_DIVIDE: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            case (div_cnt_ff)
               hctm_pkg::DivCntW'(0): rep_ff <= mul_p[63:28];
               hctm_pkg::DivCntW'(1): lo_ff <= mul_p[63:28];
               hctm_pkg::DivCntW'(2): ru_ff <= mul_p[63:28];
               hctm_pkg::DivCntW'(3): rp_ff <= mul_p[63:28];
               default: begin
               end
            endcase
         end
         hctm_pkg::ST_EJECT: begin
            ej_ff <= mul_p[63:28];
         end
         hctm_pkg::ST_UPDATE: begin
            cleft_ff <= pool_new.cleft_pool;
         end
         hctm_pkg::ST_RATE: begin
            full_ff <= mul_p[47:12];
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_ff.rate <= rate_val;
         rsp_ff.out_channel <= chan_ff;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a transaction while another was in progress");

   assert property (@(posedge clock) disable iff (reset)
      state_ff != hctm_pkg::ST_DIVIDE |-> div_cnt_ff == '0)
      else $error("divider count active outside the divide state");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == hctm_pkg::ST_UPDATE |-> !skip_ff)
      else $error("pool write-back for a channel out of range");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == hctm_pkg::ST_UPDATE |=> valid_ff[$past(idx_ff)])
      else $error("channel not marked written after write-back");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> state_ff == hctm_pkg::ST_OUTPUT && (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while holding a result");
`endif

endmodule

`default_nettype wire

/* verif/hair_cell_transmitter_model_top_tb.sv */
`timescale 1ns / 1ps

module hair_cell_transmitter_model_top_tb;

   localparam longint unsigned Unity = 64'd268435456;
   localparam longint unsigned SteadyFree = (Unity * 64'd5594348000) / 64'd15594188000;
   localparam longint unsigned SteadyCleft = (Unity * 64'd10100) / 64'd7797094;
   localparam longint unsigned SteadyStore =
      (Unity * 64'd6645800000) / (64'd7797094 * 64'd6631);
   localparam longint PermOffset = 1280;
   localparam longint unsigned PermKnee = 76800;
   localparam longint unsigned SpikeGain = 50000;
   localparam longint PoolTop = 64'sd4294967295;
   localparam logic [2:0] CsrReserved = 3'd7;
   localparam int PhaseCount = 8;
   localparam int PhaseItems = 80;
   localparam int DirectedCount = 16;
   localparam int SettleCycles = 20;

   class transmitter_scoreboard;
      logic [31:0] free_lvl [hctm_pkg::Channels];
      logic [31:0] cleft_lvl [hctm_pkg::Channels];
      logic [31:0] store_lvl [hctm_pkg::Channels];
      logic [31:0] perm_gain;
      logic [31:0] refill_rate;
      logic [31:0] loss_rate;
      logic [31:0] uptake_rate;
      logic [31:0] recycle_rate;
      logic spont_on;
      logic [31:0] spont_rate;
      hctm_pkg::rsp_type expected_rates [$];
      int errors;

      function new();
         errors = 0;
         for (int i = 0; i < hctm_pkg::Channels; i++) begin
            free_lvl[i] = 32'(SteadyFree);
            cleft_lvl[i] = 32'(SteadyCleft);
            store_lvl[i] = 32'(SteadyStore);
         end
         perm_gain = hctm_pkg::RstGainDt;
         refill_rate = hctm_pkg::RstReplenishDt;
         loss_rate = hctm_pkg::RstLossDt;
         uptake_rate = hctm_pkg::RstReuptakeDt;
         recycle_rate = hctm_pkg::RstReprocessDt;
         spont_on = 1'b0;
         spont_rate = hctm_pkg::RstSpontLevel;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            hctm_pkg::CSR_GAIN_DT: perm_gain = data;
            hctm_pkg::CSR_REPLENISH_DT: refill_rate = data;
            hctm_pkg::CSR_LOSS_DT: loss_rate = data;
            hctm_pkg::CSR_REUPTAKE_DT: uptake_rate = data;
            hctm_pkg::CSR_REPROCESS_DT: recycle_rate = data;
            hctm_pkg::CSR_SUBTRACT_SPONT: spont_on = data[0];
            hctm_pkg::CSR_SPONT_LEVEL: spont_rate = data;
            default: ;
         endcase
      endfunction

      function longint unsigned scale_q28(longint unsigned a, longint unsigned b);
         return (a * b) >> 28;
      endfunction

      function logic [31:0] clamp_level(longint v);
         if (v < 0) return 32'd0;
         if (v > PoolTop) return 32'hFFFF_FFFF;
         return 32'(v);
      endfunction

      function void note_sample(hctm_pkg::req_type r);
         longint lim;
         longint level;
         longint unsigned kt, q, c, w, room, refill, eject, loss, uptake, recycle;
         hctm_pkg::rsp_type e;
         e.out_channel = r.channel;
         e.rate = 32'd0;
         if (r.channel < hctm_pkg::Channels) begin
            lim = longint'($signed(r.sample)) + PermOffset;
            if (lim < 0) lim = 0;
            kt = (64'(lim) * 64'(perm_gain)) / (64'(lim) + PermKnee);
            q = 64'(free_lvl[r.channel]);
            c = 64'(cleft_lvl[r.channel]);
            w = 64'(store_lvl[r.channel]);
            room = (q < Unity) ? (Unity - q) : 64'd0;
            refill = scale_q28(64'(refill_rate), room);
            eject = scale_q28(kt, q);
            loss = scale_q28(64'(loss_rate), c);
            uptake = scale_q28(64'(uptake_rate), c);
            recycle = scale_q28(64'(recycle_rate), w);
            free_lvl[r.channel] = clamp_level(longint'(q) + longint'(refill)
                                              - longint'(eject) + longint'(recycle));
            cleft_lvl[r.channel] = clamp_level(longint'(c) + longint'(eject)
                                               - longint'(loss) - longint'(uptake));
            store_lvl[r.channel] = clamp_level(longint'(w) + longint'(uptake)
                                               - longint'(recycle));
            level = longint'((SpikeGain * 64'(cleft_lvl[r.channel])) >> 12);
            if (spont_on) begin
               level = level - longint'(spont_rate);
               if (level < 0) level = 0;
            end
            e.rate = clamp_level(level);
         end
         expected_rates.push_back(e);
      endfunction

      function void check_rate(hctm_pkg::rsp_type got);
         hctm_pkg::rsp_type want;
         if (expected_rates.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction: expected none, actual rate %h channel %0d",
                     $time, got.rate, got.out_channel);
         end else begin
            want = expected_rates.pop_front();
            if (got.rate !== want.rate) begin
               errors++;
               $display("%0t: rate mismatch on channel %0d: expected %h, actual %h",
                        $time, want.out_channel, want.rate, got.rate);
            end
            if (got.out_channel !== want.out_channel) begin
               errors++;
               $display("%0t: channel mismatch: expected %0d, actual %0d",
                        $time, want.out_channel, got.out_channel);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hctm_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hctm_pkg::rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   bit idling_on = 1'b1;
   int stall_left = 0;
   transmitter_scoreboard sb = new();

   int directed_samples [DirectedCount] = '{0, 8388607, -8388608, -1280, -1281, -1279, 1, -1,
                                            8388607, 8388607, -8388608, 256, -65536, 65535,
                                            4194304, -4194305};
   int directed_channels [DirectedCount] = '{0, 31, 1, 2, 3, 4, 5, 6, 0, 0, 0, 7, 8, 16, 31, 15};

   hair_cell_transmitter_model_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_rate(rsp_payload);
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input hctm_pkg::req_type item);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(item);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(input logic [31:0] gain, input logic [31:0] refill,
                            input logic [31:0] loss, input logic [31:0] uptake,
                            input logic [31:0] recycle, input logic spont_on,
                            input logic [31:0] spont);
      write_reg(hctm_pkg::CSR_GAIN_DT, gain);
      write_reg(hctm_pkg::CSR_REPLENISH_DT, refill);
      write_reg(hctm_pkg::CSR_LOSS_DT, loss);
      write_reg(hctm_pkg::CSR_REUPTAKE_DT, uptake);
      write_reg(hctm_pkg::CSR_REPROCESS_DT, recycle);
      write_reg(hctm_pkg::CSR_SUBTRACT_SPONT, {31'($urandom), spont_on});
      write_reg(hctm_pkg::CSR_SPONT_LEVEL, spont);
      write_reg(CsrReserved, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_rates.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_rate(input logic [31:0] typical);
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(typical / 2, typical * 3);
      endcase
   endfunction

   function automatic hctm_pkg::req_type pick_sample();
      hctm_pkg::req_type item;
      case ($urandom_range(0, 5))
         0: item.sample = 24'($urandom);
         1: item.sample = 24'(int'($urandom_range(0, 4000)) - 3280);
         2: item.sample = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
         default: item.sample = 24'(int'($urandom_range(0, 131072)) - 65536);
      endcase
      item.channel = $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      return item;
   endfunction

   initial begin
      hctm_pkg::req_type item;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PhaseCount; p++) begin
         idling_on = (p != PhaseCount - 1);
         if (p > 0) begin
            settle();
            case (p)
               1: configure('0, '0, '0, '0, '0, 1'b0, '0);
               2: configure('1, '1, '1, '1, '1, 1'b0, '1);
               3: configure(hctm_pkg::RstGainDt, hctm_pkg::RstReplenishDt,
                            hctm_pkg::RstLossDt, hctm_pkg::RstReuptakeDt,
                            hctm_pkg::RstReprocessDt, 1'b1, hctm_pkg::RstSpontLevel);
               PhaseCount - 1: configure(hctm_pkg::RstGainDt, hctm_pkg::RstReplenishDt,
                                         hctm_pkg::RstLossDt, hctm_pkg::RstReuptakeDt,
                                         hctm_pkg::RstReprocessDt, 1'($urandom),
                                         hctm_pkg::RstSpontLevel);
               default: configure(pick_rate(hctm_pkg::RstGainDt),
                                  pick_rate(hctm_pkg::RstReplenishDt),
                                  pick_rate(hctm_pkg::RstLossDt),
                                  pick_rate(hctm_pkg::RstReuptakeDt),
                                  pick_rate(hctm_pkg::RstReprocessDt), 1'($urandom),
                                  pick_rate(hctm_pkg::RstSpontLevel));
            endcase
         end else begin
            for (int k = 0; k < DirectedCount; k++) begin
               item.sample = 24'(directed_samples[k]);
               item.channel = 5'(directed_channels[k]);
               send_sample(item);
            end
         end
         repeat (PhaseItems) send_sample(pick_sample());
      end
      settle();
      if (sb.errors == 0 && sb.expected_rates.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/hctm_pkg.sv
rtl/hair_cell_transmitter_model_top.sv
verif/hair_cell_transmitter_model_top_tb.sv
